FILE: rtl/lri_pkg.sv
// ============================================================================
// lri_pkg: shared definitions for the linear interpolation resampler
// Widths, fixed-point constants, register indexes and lane control types.
// ============================================================================
package lri_pkg;

  // Lanes built in hardware and lanes carried by the payload
  localparam int ChannelLanes = 8;
  localparam int FieldLanes   = 8;
  localparam int LanesUsed    = (ChannelLanes < FieldLanes) ? ChannelLanes : FieldLanes;

  localparam int SampleW   = 16;
  localparam int RateW     = 17;
  localparam int CountW    = 4;
  localparam int PhaseW    = 19;
  localparam int StepW     = 18;
  localparam int FracBits  = 14;
  localparam int CfgDataW  = RateW;
  localparam int CfgIndexW = 2;
  localparam int DivW      = RateW + FracBits;

  localparam logic [PhaseW-1:0] OneQ      = PhaseW'(1 << FracBits);
  localparam logic [StepW-1:0]  StepMax   = StepW'(262143);
  localparam logic [StepW-1:0]  StepMin   = StepW'(1261);
  localparam logic [StepW-1:0]  StepReset = StepW'(1 << FracBits);
  localparam logic [RateW-1:0]  RateReset = RateW'(44100);
  localparam logic [CountW-1:0] CountReset = CountW'(2);

  localparam logic OpFrame   = 1'b0;
  localparam logic OpRestart = 1'b1;

  typedef logic signed [SampleW-1:0] sample_t;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_INPUT_RATE    = 2'd0,
    CFG_OUTPUT_RATE   = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_index_t;

  // Per-lane control from the sequencer
  typedef struct packed {
    logic clear;   // restart: zero the history
    logic load;    // capture the incoming sample
    logic commit;  // current sample becomes history
    logic active;  // lane is in use
  } lane_ctl_t;

endpackage

FILE: rtl/lri_step_div.sv
// ============================================================================
// lri_step_div: phase step divider
// Restoring divider, one quotient bit per cycle: input_rate*2^14/output_rate,
// clamped to the legal step range, held in the step register.
// ============================================================================
module lri_step_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lri_pkg::RateW-1:0]  input_rate,
  input  logic [lri_pkg::RateW-1:0]  output_rate,
  output logic [lri_pkg::StepW-1:0]  phase_step,
  output logic                       busy
);
  import lri_pkg::*;

  localparam int CntW = $clog2(DivW + 1);

  typedef enum logic {DIV_IDLE, DIV_RUN} div_state_t;

  div_state_t         state;
  logic [CntW-1:0]    count;
  logic [DivW-1:0]    dividend;
  logic [RateW-1:0]   remainder;
  logic [DivW-1:0]    quotient;

  logic [RateW:0]     rem_shift;
  logic [RateW:0]     rem_sub;
  logic               fits;
  logic [DivW-1:0]    quotient_next;
  logic [StepW-1:0]   step_clamped;

  always_comb begin
    rem_shift     = {remainder, dividend[DivW-1]};
    fits          = rem_shift >= {1'b0, output_rate};
    rem_sub       = rem_shift - {1'b0, output_rate};
    quotient_next = {quotient[DivW-2:0], fits};
    if (quotient_next > DivW'(StepMax)) begin
      step_clamped = StepMax;
    end else if (quotient_next < DivW'(StepMin)) begin
      step_clamped = StepMin;
    end else begin
      step_clamped = quotient_next[StepW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= DIV_IDLE;
      count      <= '0;
      phase_step <= StepReset;
    end else if (start) begin
      if (output_rate == '0) begin
        phase_step <= StepMax;
        state      <= DIV_IDLE;
      end else begin
        dividend  <= {input_rate, FracBits'(0)};
        remainder <= '0;
        quotient  <= '0;
        count     <= CntW'(DivW);
        state     <= DIV_RUN;
      end
    end else if (state == DIV_RUN) begin
      dividend  <= {dividend[DivW-2:0], 1'b0};
      remainder <= fits ? rem_sub[RateW-1:0] : rem_shift[RateW-1:0];
      quotient  <= quotient_next;
      count     <= count - CntW'(1);
      if (count == CntW'(1)) begin
        phase_step <= step_clamped;
        state      <= DIV_IDLE;
      end
    end
  end

  assign busy = (state == DIV_RUN);

endmodule

FILE: rtl/lri_lane.sv
// ============================================================================
// lri_lane: one interpolation lane
// Holds the previous and current sample of one channel and forms
// (prev*(1-frac) + cur*frac) in Q14, floored.
// ============================================================================
module lri_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  lri_pkg::lane_ctl_t            ctl,
  input  lri_pkg::sample_t              sample,
  input  logic [lri_pkg::FracBits-1:0]  frac,
  output lri_pkg::sample_t              result,
  output lri_pkg::sample_t              current
);
  import lri_pkg::*;

  localparam int WgtW  = FracBits + 2;
  localparam int ProdW = SampleW + WgtW;

  sample_t                   prev;
  sample_t                   cur;
  logic [WgtW-1:0]           w_prev;
  logic [WgtW-1:0]           w_cur;
  logic signed [ProdW-1:0]   prod_prev;
  logic signed [ProdW-1:0]   prod_cur;
  logic signed [ProdW-1:0]   sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
    end else if (ctl.clear) begin
      prev <= '0;
    end else if (ctl.commit && ctl.active) begin
      prev <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cur <= sample;
    end
  end

  always_comb begin
    w_cur     = {2'b00, frac};
    w_prev    = WgtW'(1 << FracBits) - w_cur;
    prod_prev = prev * $signed(w_prev);
    prod_cur  = cur * $signed(w_cur);
    sum       = prod_prev + prod_cur;
  end

  // floor shift by the fraction width
  assign result  = sum[FracBits+SampleW-1:FracBits];
  assign current = cur;

endmodule

FILE: rtl/linear_interp_resampler_top.sv
// ============================================================================
// linear_interp_resampler_top: linear interpolation sample rate converter
// Eight interpolation lanes share one Q14 phase; a sequencer walks the phase
// and an output register merges the lanes into one output frame per cycle while not stalled.
// ============================================================================
// One request carries one multichannel frame (or a restart). The block takes
// a request, then emits its output frames one by one, advancing the phase
// after each, and ends with a closing step that advances the history; a frame
// yields at most 13 output frames, possibly none. A pass-through frame (equal
// rates) is sent on as a single final frame; a restart clears the history and
// the phase. The phase sequencer serves one frame at a time while all eight
// lanes compute in parallel. A finished output frame sits in the output
// register, so a stalled consumer holds only that register until the
// sequencer needs it again. Writing either rate register starts a bit-serial
// divider that forms the Q14 phase step; requests are stalled meanwhile.
// Writing channel_count takes effect at once; unused lanes read as zero.
// ============================================================================
module linear_interp_resampler_top (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic [lri_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [lri_pkg::CfgDataW-1:0]   cfg_data,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           op,
  input  lri_pkg::sample_t               sample_0,
  input  lri_pkg::sample_t               sample_1,
  input  lri_pkg::sample_t               sample_2,
  input  lri_pkg::sample_t               sample_3,
  input  lri_pkg::sample_t               sample_4,
  input  lri_pkg::sample_t               sample_5,
  input  lri_pkg::sample_t               sample_6,
  input  lri_pkg::sample_t               sample_7,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output lri_pkg::sample_t               out_0,
  output lri_pkg::sample_t               out_1,
  output lri_pkg::sample_t               out_2,
  output lri_pkg::sample_t               out_3,
  output lri_pkg::sample_t               out_4,
  output lri_pkg::sample_t               out_5,
  output lri_pkg::sample_t               out_6,
  output lri_pkg::sample_t               out_7,
  output logic                           last
);
  import lri_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_EMIT, ST_PASS} state_t;

  // configuration registers
  logic [RateW-1:0]   input_rate;
  logic [RateW-1:0]   output_rate;
  logic [CountW-1:0]  channel_count;
  logic               div_start;
  logic               div_busy;
  logic [StepW-1:0]   phase_step;

  // sequencer
  state_t             state;
  logic [PhaseW-1:0]  phase;
  logic [PhaseW:0]    phase_sum;
  logic               accept;
  logic               out_free;
  logic               out_load;
  logic               frame_done;
  logic               rates_equal;

  // lanes
  logic [CountW:0]    lanes_in_use;
  logic [FieldLanes-1:0] active;
  sample_t            sample_in   [FieldLanes];
  sample_t            lane_result [FieldLanes];
  sample_t            lane_cur    [FieldLanes];
  sample_t            lerp_data   [FieldLanes];
  sample_t            pass_data   [FieldLanes];
  lane_ctl_t          lane_ctl    [FieldLanes];

  // output register
  sample_t            out_data    [FieldLanes];
  logic               out_last;

  assign sample_in[0] = sample_0;
  assign sample_in[1] = sample_1;
  assign sample_in[2] = sample_2;
  assign sample_in[3] = sample_3;
  assign sample_in[4] = sample_4;
  assign sample_in[5] = sample_5;
  assign sample_in[6] = sample_6;
  assign sample_in[7] = sample_7;

  // --------------------------------------------------------------------------
  // Configuration: a rate write kicks the divider on the following cycle,
  // once the new rate is in its register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      input_rate    <= RateReset;
      output_rate   <= RateReset;
      channel_count <= CountReset;
      div_start     <= 1'b0;
    end else begin
      div_start <= cfg_write &&
                   (cfg_index == CFG_INPUT_RATE || cfg_index == CFG_OUTPUT_RATE);
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_INPUT_RATE:    input_rate    <= cfg_data;
          CFG_OUTPUT_RATE:   output_rate   <= cfg_data;
          CFG_CHANNEL_COUNT: channel_count <= cfg_data[CountW-1:0];
          default: ;
        endcase
      end
    end
  end

  lri_step_div u_step_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .input_rate  (input_rate),
    .output_rate (output_rate),
    .phase_step  (phase_step),
    .busy        (div_busy)
  );

  // --------------------------------------------------------------------------
  // Lane usage: a count of zero acts as one, a count above the built lanes
  // saturates.
  // --------------------------------------------------------------------------
  always_comb begin
    if (channel_count == '0) begin
      lanes_in_use = (CountW+1)'(1);
    end else if ({1'b0, channel_count} > (CountW+1)'(LanesUsed)) begin
      lanes_in_use = (CountW+1)'(LanesUsed);
    end else begin
      lanes_in_use = {1'b0, channel_count};
    end
    for (int c = 0; c < FieldLanes; c++) begin
      active[c] = (CountW+1)'(c) < lanes_in_use;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and sequencer decode
  // --------------------------------------------------------------------------
  assign in_stall    = (state != ST_IDLE) || div_start || div_busy;
  assign accept      = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign rates_equal = (input_rate == output_rate);
  assign frame_done  = (phase >= OneQ);
  assign phase_sum   = {1'b0, phase} + (PhaseW+1)'(phase_step);
  // load the output register with a new frame this cycle
  assign out_load    = out_free &&
                       (((state == ST_EMIT) && !frame_done) || (state == ST_PASS));

  always_comb begin
    for (int c = 0; c < FieldLanes; c++) begin
      lane_ctl[c].clear  = accept && (op == OpRestart);
      lane_ctl[c].load   = accept && (op == OpFrame);
      lane_ctl[c].commit = (state == ST_EMIT) && frame_done;
      lane_ctl[c].active = active[c];
      lerp_data[c]       = active[c] ? lane_result[c] : '0;
      pass_data[c]       = active[c] ? lane_cur[c] : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Lanes: built up to the lane limit, the rest read as zero
  // --------------------------------------------------------------------------
  for (genvar c = 0; c < FieldLanes; c++) begin : g_lane
    if (c < LanesUsed) begin : g_built
      lri_lane u_lane (
        .clk     (clk),
        .rst     (rst),
        .ctl     (lane_ctl[c]),
        .sample  (sample_in[c]),
        .frac    (phase[FracBits-1:0]),
        .result  (lane_result[c]),
        .current (lane_cur[c])
      );
    end else begin : g_unused
      assign lane_result[c] = '0;
      assign lane_cur[c]    = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and merging output register.
  // EMIT: while the phase is below one and the output register is free, emit a frame
  // and advance the phase; once it reaches one, drop it by one and move the frame into history.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      // hold the frame while stalled, drop it once taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (op == OpRestart) begin
              phase <= '0;
            end else if (rates_equal) begin
              state <= ST_PASS;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (frame_done) begin
            phase <= phase - OneQ;
            state <= ST_IDLE;
          end else if (out_free) begin
            out_data  <= lerp_data;
            out_last  <= (phase_sum >= (PhaseW+1)'(OneQ));
            phase     <= phase_sum[PhaseW-1:0];
          end
        end
        ST_PASS: begin
          if (out_free) begin
            out_data  <= pass_data;
            out_last  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_0 = out_data[0];
  assign out_1 = out_data[1];
  assign out_2 = out_data[2];
  assign out_3 = out_data[3];
  assign out_4 = out_data[4];
  assign out_5 = out_data[5];
  assign out_6 = out_data[6];
  assign out_7 = out_data[7];
  assign last  = out_last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // a request is never taken while the step is being recomputed
  a_no_accept_during_div: assert property (@(posedge clk) disable iff (rst)
    accept |-> !div_busy)
    else $error("request accepted while divider busy");

  // a restart leaves the phase at zero
  a_restart_clears_phase: assert property (@(posedge clk) disable iff (rst)
    accept && (op == OpRestart) |=> (phase == '0) && (state == ST_IDLE))
    else $error("restart did not clear phase");

  // an emit step loads the output register and leaves the phase nonzero
  a_emit_phase_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && out_free && !frame_done |=> out_valid && (phase != '0))
    else $error("emit step did not load the output register");

  // a pass-through frame is delivered as a single final frame
  a_pass_is_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PASS) && out_free |=> out_valid && out_last && (state == ST_IDLE))
    else $error("pass-through frame not marked last");

endmodule
